### sv/opp_pkg.sv
// ----------------------------------------------------------------------------
// Operator precedence parser package
// Shared widths, codes, configuration bundle and controller/datapath links.
// ----------------------------------------------------------------------------
package opp_pkg;

  localparam int SYM_W           = 8;
  localparam int ACT_W           = 3;
  localparam int DEPTH_W         = 5;
  localparam int COUNT_W         = 4;
  localparam int MAX_TERMINALS   = 8;
  localparam int TERM_IDX_W      = 3;
  localparam int REL_W           = 2;
  localparam int TABLE_W         = 2 * 64;
  localparam int CFG_ADDR_W      = 5;
  localparam int CFG_DATA_W      = 64;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [SYM_W-1:0] END_MARK = 8'h24;

  localparam logic [COUNT_W-1:0]    TERM_COUNT_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0] TERM_CHARS_RST = 64'd36;

  typedef enum logic [REL_W-1:0] {
    REL_NONE    = 2'd0,
    REL_LESS    = 2'd1,
    REL_EQUAL   = 2'd2,
    REL_GREATER = 2'd3
  } rel_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_SHIFT   = 3'd0,
    ACT_REDUCE  = 3'd1,
    ACT_ACCEPT  = 3'd2,
    ACT_REJECT  = 3'd3,
    ACT_IGNORED = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    REG_TERM_COUNT = 2'd0,
    REG_TERM_CHARS = 2'd1,
    REG_REL_LOW    = 2'd2,
    REG_REL_HIGH   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_EXEC = 2'd2,
    ST_POP  = 2'd3
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0]    terminal_count;
    logic [CFG_DATA_W-1:0] terminal_chars;
    logic [TABLE_W-1:0]    rel_table;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic commit;
    logic pop_emit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic dec_reduce;
  } stat_t;

endpackage

### sv/opp_if.sv
// ----------------------------------------------------------------------------
// Operator precedence parser channel interfaces
// Symbol channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface opp_sym_if;
  logic                      valid;
  logic                      ready;
  logic [opp_pkg::SYM_W-1:0] symbol;
  logic                      restart;

  modport source (output valid, output symbol, output restart, input ready);
  modport sink   (input valid, input symbol, input restart, output ready);
endinterface

interface opp_res_if;
  logic                        valid;
  logic                        ready;
  logic [opp_pkg::ACT_W-1:0]   action;
  logic [opp_pkg::SYM_W-1:0]   top_symbol;
  logic [opp_pkg::DEPTH_W-1:0] stack_depth;
  logic                        last;

  modport source (output valid, output action, output top_symbol, output stack_depth,
                  output last, input ready);
  modport sink   (input valid, input action, input top_symbol, input stack_depth,
                  input last, output ready);
endinterface

### sv/opp_regs.sv
// ----------------------------------------------------------------------------
// Operator precedence parser configuration registers
// APB register file holding the terminal set and the relation table.
// ----------------------------------------------------------------------------
module opp_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [opp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [opp_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [opp_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output opp_pkg::cfg_t                      cfg_o
);
  import opp_pkg::*;

  logic                  wr_en;
  reg_e                  reg_sel;
  logic [COUNT_W-1:0]    term_count_q;
  logic [CFG_DATA_W-1:0] term_chars_q;
  logic [CFG_DATA_W-1:0] rel_low_q;
  logic [CFG_DATA_W-1:0] rel_high_q;

  // Decode the register slot from the 8-byte aligned address
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[4:3]);
  assign pready  = 1'b1;

  // Store writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RST;
      term_chars_q <= TERM_CHARS_RST;
      rel_low_q    <= '0;
      rel_high_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TERM_COUNT: term_count_q <= pwdata[COUNT_W-1:0];
        REG_TERM_CHARS: term_chars_q <= pwdata;
        REG_REL_LOW:    rel_low_q    <= pwdata;
        REG_REL_HIGH:   rel_high_q   <= pwdata;
        default:        term_count_q <= term_count_q;
      endcase
    end
  end

  // Return the selected register
  always_comb begin
    unique case (reg_sel)
      REG_TERM_COUNT: prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, term_count_q};
      REG_TERM_CHARS: prdata = term_chars_q;
      REG_REL_LOW:    prdata = rel_low_q;
      REG_REL_HIGH:   prdata = rel_high_q;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.terminal_count = term_count_q;
  assign cfg_o.terminal_chars = term_chars_q;
  assign cfg_o.rel_table      = {rel_high_q, rel_low_q};

endmodule

### sv/opp_ctrl.sv
// ----------------------------------------------------------------------------
// Operator precedence parser controller
// Sequences take, evaluate, execute and pop steps for each symbol.
// ----------------------------------------------------------------------------
module opp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  opp_pkg::stat_t  stat_i,
  output opp_pkg::cmd_t   cmd_o
);
  import opp_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: state_d = ST_EXEC;
      ST_EXEC: begin
        if (stat_i.dec_reduce) state_d = ST_POP;
        else if (stat_i.slot_free) state_d = ST_IDLE;
      end
      ST_POP: begin
        if (stat_i.slot_free) state_d = ST_EVAL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_EVAL: cmd_o.eval = 1'b1;
      ST_EXEC: cmd_o.commit = stat_i.dec_reduce | stat_i.slot_free;
      ST_POP:  cmd_o.pop_emit = stat_i.slot_free;
      default: in_ready_o = 1'b0;
    endcase
  end

endmodule

### sv/opp_dpath.sv
// ----------------------------------------------------------------------------
// Operator precedence parser datapath
// Symbol stack, terminal lookup, relation decision and result register.
// ----------------------------------------------------------------------------
module opp_dpath #(
  parameter int STACK_DEPTH = opp_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  opp_pkg::cfg_t                cfg_i,
  input  opp_pkg::cmd_t                cmd_i,
  output opp_pkg::stat_t               stat_o,
  input  logic [opp_pkg::SYM_W-1:0]    symbol_i,
  input  logic                         restart_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [opp_pkg::ACT_W-1:0]    action_o,
  output logic [opp_pkg::SYM_W-1:0]    top_symbol_o,
  output logic [opp_pkg::DEPTH_W-1:0]  stack_depth_o,
  output logic                         last_o
);
  import opp_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(STACK_DEPTH);

  typedef struct packed {
    logic                  hit;
    logic [TERM_IDX_W-1:0] idx;
  } term_hit_t;

  // Highest-indexed terminal among the first count entries that equals c
  function automatic term_hit_t find_term(input logic [SYM_W-1:0]      c,
                                          input logic [CFG_DATA_W-1:0] chars,
                                          input logic [COUNT_W-1:0]    count);
    term_hit_t res;
    res = '0;
    for (int k = 0; k < MAX_TERMINALS; k++) begin
      if ((COUNT_W'(k) < count) && (chars[SYM_W*k +: SYM_W] == c)) begin
        res.hit = 1'b1;
        res.idx = TERM_IDX_W'(k);
      end
    end
    return res;
  endfunction

  logic [SYM_W-1:0]  mem [STACK_DEPTH:0];
  logic [SYM_W-1:0]  rd_q;
  logic [SYM_W-1:0]  sym_q;
  logic [SYM_W-1:0]  top_q, top_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  idx_inc;
  logic              finished_q, finished_d;
  action_e           dec_q, dec_d;

  logic              out_valid_q, out_valid_d;
  action_e           out_act_q, out_act_d;
  logic [SYM_W-1:0]  out_top_q, out_top_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  logic [IDX_W+DEPTH_W-1:0] depth_ext;

  term_hit_t         row_hit, col_hit;
  rel_e              rel;
  logic              mem_we;
  logic              emit;
  logic [SYM_W-1:0]  popped;

  assign idx_inc = idx_q + 1'b1;
  assign popped  = (idx_q == '0) ? END_MARK : rd_q;

  // Look up the relation between stack top and input symbol
  assign row_hit = find_term(top_q, cfg_i.terminal_chars, cfg_i.terminal_count);
  assign col_hit = find_term(sym_q, cfg_i.terminal_chars, cfg_i.terminal_count);
  assign rel     = rel_e'(cfg_i.rel_table[{row_hit.idx, col_hit.idx, 1'b0} +: REL_W]);

  // Decide the next action
  always_comb begin
    if (finished_q) begin
      dec_d = ACT_IGNORED;
    end else if ((top_q == END_MARK) && (sym_q == END_MARK)) begin
      dec_d = ACT_ACCEPT;
    end else if (!row_hit.hit || !col_hit.hit || (rel == REL_NONE)) begin
      dec_d = ACT_REJECT;
    end else if (rel == REL_GREATER) begin
      dec_d = (idx_q == '0) ? ACT_REJECT : ACT_REDUCE;
    end else begin
      dec_d = (idx_q == IDX_FULL) ? ACT_REJECT : ACT_SHIFT;
    end
  end

  // Apply the decision to the stack and stage the result
  always_comb begin
    top_d      = top_q;
    idx_d      = idx_q;
    finished_d = finished_q;
    mem_we     = 1'b0;
    emit       = 1'b0;
    out_act_d  = dec_q;
    out_top_d  = top_q;
    out_idx_d  = idx_q;
    out_last_d = 1'b1;
    if (cmd_i.load_item && restart_i) begin
      top_d      = END_MARK;
      idx_d      = '0;
      finished_d = 1'b0;
    end
    if (cmd_i.commit) begin
      case (dec_q)
        ACT_SHIFT: begin
          mem_we    = 1'b1;
          idx_d     = idx_inc;
          top_d     = sym_q;
          emit      = 1'b1;
          out_top_d = sym_q;
          out_idx_d = idx_inc;
        end
        ACT_REDUCE: idx_d = idx_q - 1'b1;
        ACT_ACCEPT, ACT_REJECT: begin
          finished_d = 1'b1;
          emit       = 1'b1;
        end
        default: emit = 1'b1;
      endcase
    end
    if (cmd_i.pop_emit) begin
      top_d      = popped;
      emit       = 1'b1;
      out_act_d  = ACT_REDUCE;
      out_top_d  = popped;
      out_last_d = 1'b0;
    end
  end

  assign out_valid_d = emit | (out_valid_q & ~out_ready_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= END_MARK;
      idx_q       <= '0;
      finished_q  <= 1'b0;
      dec_q       <= ACT_IGNORED;
      out_valid_q <= 1'b0;
    end else begin
      top_q       <= top_d;
      idx_q       <= idx_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.eval) dec_q <= dec_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) sym_q <= symbol_i;
    if (emit) begin
      out_act_q  <= out_act_d;
      out_top_q  <= out_top_d;
      out_idx_q  <= out_idx_d;
      out_last_q <= out_last_d;
    end
  end

  // Stack memory: push on shift, read the entry under the next top index
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[idx_inc] <= sym_q;
    rd_q <= mem[idx_d];
  end

  assign depth_ext = {{DEPTH_W{1'b0}}, out_idx_q};

  assign stat_o.slot_free  = ~out_valid_q | out_ready_i;
  assign stat_o.dec_reduce = (dec_q == ACT_REDUCE);

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_act_q;
  assign top_symbol_o  = out_top_q;
  assign stack_depth_o = depth_ext[DEPTH_W-1:0];
  assign last_o        = out_last_q;

endmodule

### sv/operator_precedence_parser_unit.sv
// ----------------------------------------------------------------------------
// Operator precedence parser unit
// Shift/reduce recognizer over a configured table of precedence relations.
//
//   channel | direction | handshake          | payload
//   sym_i   | in        | valid/ready        | symbol[7:0], restart
//   res_o   | out       | valid/ready        | action[2:0], top_symbol[7:0],
//           |           |                    | stack_depth[4:0], last
//   apb     | in        | psel/penable/pready| paddr[4:0], pwdata/prdata[63:0]
//
// A symbol is taken, evaluated and executed for its final result; each reduce
// adds a pop and another evaluation and execution, looping around the single
// stack read port. The next symbol is taken while a result is still held.
// A stalled result channel holds the controller in execute or pop.
// Reset leaves the end marker on top with an empty stack; no clearing pass.
// ----------------------------------------------------------------------------
module operator_precedence_parser_unit #(
  parameter int STACK_DEPTH = opp_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  opp_sym_if.sink                         sym_i,
  opp_res_if.source                       res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [opp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [opp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [opp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import opp_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  sym_ready;

  assign sym_i.ready = sym_ready;

  opp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  opp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sym_i.valid),
    .in_ready_o (sym_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  opp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .symbol_i      (sym_i.symbol),
    .restart_i     (sym_i.restart),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .action_o      (res_o.action),
    .top_symbol_o  (res_o.top_symbol),
    .stack_depth_o (res_o.stack_depth),
    .last_o        (res_o.last)
  );

  // Only reduce results leave the transaction open
  a_reduce_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.action == ACT_REDUCE)) |-> !res_o.last)
    else $error("reduce result marked last");

  a_final_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.action != ACT_REDUCE)) |-> res_o.last)
    else $error("final result not marked last");

  // A taken symbol is evaluated in the following cycle
  a_load_then_eval : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_item |=> cmd.eval)
    else $error("symbol taken without evaluation");

  // A final action frees the input side
  a_final_then_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && !stat.dec_reduce) |=> sym_ready)
    else $error("input not ready after final action");

endmodule
